// ===== src/stpe_pkg.sv =====
// Shared types, constants and codes for the sparse trivariate polynomial evaluator.
package stpe_pkg;

    localparam int EXP_BITS_DEF = 4;
    localparam int COEF_W       = 16;
    localparam int POINT_W      = 16;
    localparam int SUM_W        = 32;
    localparam int CFG_IDX_W    = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_POINT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_POINT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_POINT = 2'd2;

    typedef enum logic [1:0] {
        VAR_X,
        VAR_Y,
        VAR_Z
    } t_var;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STEP,
        ST_ACC
    } t_state;

    typedef struct packed {
        logic load_item;
        logic load_var;
        t_var var_sel;
        logic mul_term;
        logic square;
        logic accum;
    } t_dp_cmd;

    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
        logic last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== src/stpe_ctrl.sv =====
// Sequencer for the evaluator: walks the three powers bit by bit on the shared multiplier.
module stpe_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  stpe_pkg::t_dp_status i_status,
    output stpe_pkg::t_dp_cmd    o_cmd
);

    stpe_pkg::t_state r_state, n_state;
    stpe_pkg::t_var   r_var, n_var;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stpe_pkg::ST_IDLE;
            r_var   <= stpe_pkg::VAR_X;
        end else begin
            r_state <= n_state;
            r_var   <= n_var;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_var          = r_var;
        o_cmd          = '0;
        o_cmd.var_sel  = r_var;
        o_s_tready     = 1'b0;
        unique case (r_state)
            stpe_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    n_var           = stpe_pkg::VAR_X;
                    n_state         = stpe_pkg::ST_LOAD;
                end
            end
            stpe_pkg::ST_LOAD: begin
                o_cmd.load_var = 1'b1;
                n_state        = stpe_pkg::ST_STEP;
            end
            stpe_pkg::ST_STEP: begin
                if (i_status.exp_zero) begin
                    // power done: advance to the next variable or accumulate
                    unique case (r_var)
                        stpe_pkg::VAR_X: begin
                            n_var   = stpe_pkg::VAR_Y;
                            n_state = stpe_pkg::ST_LOAD;
                        end
                        stpe_pkg::VAR_Y: begin
                            n_var   = stpe_pkg::VAR_Z;
                            n_state = stpe_pkg::ST_LOAD;
                        end
                        default: begin
                            n_state = stpe_pkg::ST_ACC;
                        end
                    endcase
                end else if (i_status.exp_lsb) begin
                    o_cmd.mul_term = 1'b1;
                end else begin
                    o_cmd.square = 1'b1;
                end
            end
            stpe_pkg::ST_ACC: begin
                // on the last term, hold while a finished sum still sits in the output register untaken
                if (!i_status.last || i_status.out_free) begin
                    o_cmd.accum = 1'b1;
                    n_state     = stpe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stpe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/stpe_dp.sv =====
// Datapath of the evaluator: point registers, shared multiplier, term, accumulator, output word.
module stpe_dp #(
    parameter int EXP_BITS = stpe_pkg::EXP_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  stpe_pkg::t_dp_cmd                  i_cmd,
    output stpe_pkg::t_dp_status               o_status,
    input  logic signed [stpe_pkg::COEF_W-1:0] i_coefficient,
    input  logic [EXP_BITS-1:0]                i_x_exponent,
    input  logic [EXP_BITS-1:0]                i_y_exponent,
    input  logic [EXP_BITS-1:0]                i_z_exponent,
    input  logic                               i_last_term,
    input  logic                               i_cfg_we,
    input  logic [stpe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [stpe_pkg::POINT_W-1:0]       i_cfg_data,
    input  logic                               i_m_tready,
    output logic                               o_m_tvalid,
    output logic [stpe_pkg::SUM_W-1:0]         o_m_tdata
);

    logic signed [stpe_pkg::POINT_W-1:0] r_x_point, r_y_point, r_z_point;
    logic [EXP_BITS-1:0]                 r_ex, r_ey, r_ez, r_exp;
    logic                                r_last;
    logic [stpe_pkg::SUM_W-1:0]          r_term, r_base, r_sum, r_out;
    logic                                r_out_valid;

    logic signed [stpe_pkg::POINT_W-1:0] sel_point;
    logic [EXP_BITS-1:0]                 sel_exp;
    logic [stpe_pkg::SUM_W-1:0]          mul_a, product, sum_new;
    logic                                out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_point <= '0;
            r_y_point <= '0;
            r_z_point <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                stpe_pkg::REG_X_POINT: r_x_point <= i_cfg_data;
                stpe_pkg::REG_Y_POINT: r_y_point <= i_cfg_data;
                stpe_pkg::REG_Z_POINT: r_z_point <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_cmd.var_sel)
            stpe_pkg::VAR_X: begin
                sel_point = r_x_point;
                sel_exp   = r_ex;
            end
            stpe_pkg::VAR_Y: begin
                sel_point = r_y_point;
                sel_exp   = r_ey;
            end
            default: begin
                sel_point = r_z_point;
                sel_exp   = r_ez;
            end
        endcase
    end

    // one shared 32x32 multiplier, low word only
    assign mul_a    = i_cmd.mul_term ? r_term : r_base;
    assign product  = mul_a * r_base;
    assign sum_new  = r_sum + r_term;
    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_term <= stpe_pkg::SUM_W'(i_coefficient);
            r_ex   <= i_x_exponent;
            r_ey   <= i_y_exponent;
            r_ez   <= i_z_exponent;
            r_last <= i_last_term;
        end else if (i_cmd.mul_term) begin
            r_term <= product;
        end
        if (i_cmd.load_var) begin
            r_base <= stpe_pkg::SUM_W'(sel_point);
            r_exp  <= sel_exp;
        end else if (i_cmd.mul_term) begin
            r_exp[0] <= 1'b0;
        end else if (i_cmd.square) begin
            r_base <= product;
            r_exp  <= r_exp >> 1;
        end
        if (i_cmd.accum && r_last) begin
            r_out <= sum_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accum) begin
                r_sum <= r_last ? '0 : sum_new;
            end
            if (i_cmd.accum && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.exp_zero = (r_exp == '0);
    assign o_status.exp_lsb  = r_exp[0];
    assign o_status.last     = r_last;
    assign o_status.out_free = out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule

// ===== src/sparse_trivariate_poly_eval.sv =====
// Top level of the sparse trivariate polynomial evaluator.
//
// Usage: set the evaluation point through the configuration channel (index 0 = x,
// 1 = y, 2 = z, 16-bit signed data; other indexes are ignored), then stream the
// terms of a polynomial on the slave channel, one word per term. Each word holds
// a signed 16-bit coefficient and three EXP_BITS-wide exponents; tlast marks the
// final term. After the final term the wrapped 32-bit value of the polynomial
// comes out as one word on the master channel, and the accumulator starts over.
// A new term is accepted only after the previous one has been accumulated. Each
// exponent is worked off by square-and-multiply, one multiply per cycle on a
// single shared 32x32 multiplier. The sum is registered and appears on the master
// channel in the cycle after the last term is accumulated.
// Reset (synchronous, active low) clears the point registers, the running sum and
// the output valid flag. A stalled receiver does not block input: the block keeps
// accepting terms while a finished sum waits, and only holds in its final step
// when a second finished sum would overwrite one not yet taken.
module sparse_trivariate_poly_eval #(
    parameter int  EXP_BITS  = stpe_pkg::EXP_BITS_DEF,
    localparam int S_TDATA_W = ((stpe_pkg::COEF_W + 3 * EXP_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream: terms
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata, low bit up: coefficient, x_exponent, y_exponent, z_exponent, zero pad
    input  logic [S_TDATA_W-1:0]           i_s_tdata,
    input  logic                           i_s_tlast,   // last_term
    // master stream: results
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata, low bit up: poly_value
    output logic [stpe_pkg::SUM_W-1:0]     o_m_tdata,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [stpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stpe_pkg::POINT_W-1:0]   i_cfg_data
);

    localparam int X_LSB = stpe_pkg::COEF_W;
    localparam int Y_LSB = X_LSB + EXP_BITS;
    localparam int Z_LSB = Y_LSB + EXP_BITS;

    stpe_pkg::t_dp_cmd    cmd;
    stpe_pkg::t_dp_status status;

    // configuration registers always take a write
    assign o_cfg_ready = 1'b1;

    stpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    stpe_dp #(
        .EXP_BITS (EXP_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_coefficient (i_s_tdata[stpe_pkg::COEF_W-1:0]),
        .i_x_exponent  (i_s_tdata[X_LSB +: EXP_BITS]),
        .i_y_exponent  (i_s_tdata[Y_LSB +: EXP_BITS]),
        .i_z_exponent  (i_s_tdata[Z_LSB +: EXP_BITS]),
        .i_last_term   (i_s_tlast),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_m_tdata     (o_m_tdata)
    );

endmodule

// ===== src/stpe_chk.sv =====
// Port-level checker for the evaluator, bound to the top level.
module stpe_chk #(
    parameter int  EXP_BITS  = stpe_pkg::EXP_BITS_DEF,
    localparam int S_TDATA_W = ((stpe_pkg::COEF_W + 3 * EXP_BITS + 7) / 8) * 8
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [S_TDATA_W-1:0]           i_s_tdata,
    input logic                           i_s_tlast,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [stpe_pkg::SUM_W-1:0]     o_m_tdata,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [stpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [stpe_pkg::POINT_W-1:0]   i_cfg_data
);

    // a result word stays up until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result word dropped while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result word present after reset");

    // a new result only follows the accumulate step, when input is closed
    a_rise_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result appeared while input was open");

    // after a term is accepted, input stays closed through the first steps of its evaluation
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready ##1 !o_s_tready ##1 !o_s_tready)
        else $error("input reopened too early");

endmodule

bind sparse_trivariate_poly_eval stpe_chk #(.EXP_BITS(EXP_BITS)) u_stpe_chk (.*);
